// ----- design/rwpe_pkg.sv -----
package rwpe_pkg;

	typedef enum logic [6:0] {
		PH_TAGS   = 7'b0000001,
		PH_HEADER = 7'b0000010,
		PH_FMT    = 7'b0000100,
		PH_SKIP   = 7'b0001000,
		PH_DATA   = 7'b0010000,
		PH_DONE   = 7'b0100000,
		PH_ERROR  = 7'b1000000
	} phase_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_NO_RIFF   = 3'd2;
	localparam logic [2:0] ST_NO_WAVE   = 3'd3;
	localparam logic [2:0] ST_FMT_SMALL = 3'd4;
	localparam logic [2:0] ST_NOT_PCM   = 3'd5;
	localparam logic [2:0] ST_NO_DATA   = 3'd6;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA  = 32'h6174_6164;

	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [15:0] FORMAT_PCM   = 16'd1;

	localparam logic [15:0] CHANNELS_DEFAULT = 16'd1;
	localparam logic [31:0] RATE_DEFAULT     = 32'd24000;
	localparam logic [15:0] BITS_DEFAULT     = 16'd16;

	typedef struct packed {
		logic        pcm_valid;
		logic [7:0]  pcm_out;
		logic        report_valid;
		logic [2:0]  status;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
		logic [31:0] bytes_emitted;
	} result_t;

endpackage

// ----- design/rwpe_parser.sv -----
module rwpe_parser import rwpe_pkg::*; #(
	parameter int MIN_FILE_BYTES = 44
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] file_byte,
	input  logic       is_final,
	output logic       has_result,
	output result_t    result
);

	localparam int OFS_W = $clog2(MIN_FILE_BYTES + 1);
	localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MIN_FILE_BYTES);

	logic [OFS_W-1:0] offset_q, offset_n;
	phase_t           phase_q, phase_n;
	logic [63:0]      hdr_q, hdr_n, hdr_shift;
	logic [31:0]      remain_q, remain_n, remain_inc, remain_dec;
	logic [4:0]       fmt_pos_q, fmt_pos_n;
	logic [15:0]      fmt_word_q, fmt_word_n, fmt_word_full;
	logic [15:0]      chan_q, chan_n;
	logic [31:0]      rate_q, rate_n;
	logic [15:0]      bits_q, bits_n;
	logic [31:0]      dsize_q, dsize_n;
	logic [31:0]      emitted_q, emitted_n;
	logic [2:0]       err_q, err_n;
	logic             emit;
	logic [2:0]       status;

	assign hdr_shift     = {file_byte, hdr_q[63:8]};
	assign remain_inc    = remain_q + 32'd1;
	assign remain_dec    = remain_q - 32'd1;
	assign fmt_word_full = {file_byte, fmt_word_q[7:0]};

	always_comb begin
		offset_n   = (offset_q == OFS_MAX) ? offset_q : offset_q + OFS_W'(1);
		phase_n    = phase_q;
		hdr_n      = hdr_q;
		remain_n   = remain_q;
		fmt_pos_n  = fmt_pos_q;
		fmt_word_n = fmt_word_q;
		chan_n     = chan_q;
		rate_n     = rate_q;
		bits_n     = bits_q;
		dsize_n    = dsize_q;
		emitted_n  = emitted_q;
		err_n      = err_q;
		emit       = 1'b0;
		case (phase_q)
			PH_TAGS: begin
				hdr_n = hdr_shift;
				if (offset_q == OFS_W'(3) && hdr_shift[63:32] != TAG_RIFF) begin
					phase_n = PH_ERROR;
					err_n   = ST_NO_RIFF;
				end else if (offset_q == OFS_W'(11)) begin
					if (hdr_shift[63:32] != TAG_WAVE) begin
						phase_n = PH_ERROR;
						err_n   = ST_NO_WAVE;
					end else begin
						phase_n  = PH_HEADER;
						remain_n = '0;
					end
				end
			end
			PH_HEADER: begin
				hdr_n    = hdr_shift;
				remain_n = remain_inc;
				if (remain_inc >= 32'd8) begin
					remain_n = hdr_shift[63:32];
					if (hdr_shift[31:0] == ID_FMT) begin
						if (hdr_shift[63:32] < FMT_MIN_SIZE) begin
							phase_n = PH_ERROR;
							err_n   = ST_FMT_SMALL;
						end else begin
							phase_n    = PH_FMT;
							fmt_pos_n  = '0;
							fmt_word_n = '0;
						end
					end else if (hdr_shift[31:0] == ID_DATA) begin
						dsize_n = hdr_shift[63:32];
						phase_n = (hdr_shift[63:32] != '0) ? PH_DATA : PH_DONE;
					end else if (hdr_shift[63:32] != '0) begin
						phase_n = PH_SKIP;
					end else begin
						remain_n = '0;
					end
				end
			end
			PH_FMT: begin
				if (fmt_pos_q == 5'd0) begin
					fmt_word_n[7:0] = file_byte;
				end else if (fmt_pos_q == 5'd1) begin
					fmt_word_n[15:8] = file_byte;
				end else if (fmt_pos_q < 5'd4) begin
					chan_n[{fmt_pos_q[0], 3'b000} +: 8] = file_byte;
				end else if (fmt_pos_q < 5'd8) begin
					rate_n[{fmt_pos_q[1:0], 3'b000} +: 8] = file_byte;
				end else if (fmt_pos_q == 5'd14 || fmt_pos_q == 5'd15) begin
					bits_n[{fmt_pos_q[0], 3'b000} +: 8] = file_byte;
				end
				if (fmt_pos_q == 5'd1 && fmt_word_full != FORMAT_PCM) begin
					phase_n = PH_ERROR;
					err_n   = ST_NOT_PCM;
				end else begin
					if (fmt_pos_q < 5'd16)
						fmt_pos_n = fmt_pos_q + 5'd1;
					remain_n = remain_dec;
					if (remain_dec == '0)
						phase_n = PH_HEADER;
				end
			end
			PH_SKIP: begin
				remain_n = remain_dec;
				if (remain_dec == '0)
					phase_n = PH_HEADER;
			end
			PH_DATA: begin
				emit      = 1'b1;
				emitted_n = emitted_q + 32'd1;
				remain_n  = remain_dec;
				if (remain_dec == '0)
					phase_n = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (offset_n < OFS_MAX)
			status = ST_SHORT;
		else if (phase_n == PH_ERROR)
			status = err_n;
		else if (phase_n == PH_DATA || phase_n == PH_DONE)
			status = ST_OK;
		else
			status = ST_NO_DATA;
	end

	always_comb begin
		result = '0;
		if (emit) begin
			result.pcm_valid = 1'b1;
			result.pcm_out   = file_byte;
		end
		if (is_final) begin
			result.report_valid  = 1'b1;
			result.status        = status;
			result.channels      = chan_n;
			result.sample_rate   = rate_n;
			result.sample_bits   = bits_n;
			result.data_size     = dsize_n;
			result.bytes_emitted = emitted_n;
		end
	end

	assign has_result = emit | is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			phase_q    <= PH_TAGS;
			hdr_q      <= '0;
			remain_q   <= '0;
			fmt_pos_q  <= '0;
			fmt_word_q <= '0;
			chan_q     <= CHANNELS_DEFAULT;
			rate_q     <= RATE_DEFAULT;
			bits_q     <= BITS_DEFAULT;
			dsize_q    <= '0;
			emitted_q  <= '0;
			err_q      <= ST_OK;
		end else if (accept) begin
			if (is_final) begin
				offset_q   <= '0;
				phase_q    <= PH_TAGS;
				hdr_q      <= '0;
				remain_q   <= '0;
				fmt_pos_q  <= '0;
				fmt_word_q <= '0;
				chan_q     <= CHANNELS_DEFAULT;
				rate_q     <= RATE_DEFAULT;
				bits_q     <= BITS_DEFAULT;
				dsize_q    <= '0;
				emitted_q  <= '0;
				err_q      <= ST_OK;
			end else begin
				offset_q   <= offset_n;
				phase_q    <= phase_n;
				hdr_q      <= hdr_n;
				remain_q   <= remain_n;
				fmt_pos_q  <= fmt_pos_n;
				fmt_word_q <= fmt_word_n;
				chan_q     <= chan_n;
				rate_q     <= rate_n;
				bits_q     <= bits_n;
				dsize_q    <= dsize_n;
				emitted_q  <= emitted_n;
				err_q      <= err_n;
			end
		end
	end

endmodule

// ----- design/rwpe_out_buf.sv -----
module rwpe_out_buf import rwpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_vld_q, skid_vld_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_vld_q & ~out_stall;
	assign full      = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop)
				skid_vld_q <= 1'b0;
		end else if (push) begin
			if (main_vld_q && !pop)
				skid_vld_q <= 1'b1;
			else
				main_vld_q <= 1'b1;
		end else if (pop) begin
			main_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (main_vld_q && !pop)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule

// ----- design/riff_wave_pcm_extractor.sv -----
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall   | file_byte, is_final
// result  | out       | out_valid / out_stall | pcm_valid, pcm_out, report_valid, status,
//         |           |                       | channels, sample_rate, sample_bits,
//         |           |                       | data_size, bytes_emitted
// One byte per cycle while in_stall is low; only data and final bytes make a result.
// Parser state updates in the accept cycle; the output register plus a one-entry
// skid slot carry the result.
// Reset returns the parser to the RIFF tag phase and empties both output slots.
// in_stall rises only when the skid slot is taken, i.e. one result was held back by
// out_stall while another was being produced.
module riff_wave_pcm_extractor import rwpe_pkg::*; #(
	parameter int MIN_FILE_BYTES = 44
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  file_byte,
	input  logic        is_final,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pcm_valid,
	output logic [7:0]  pcm_out,
	output logic        report_valid,
	output logic [2:0]  status,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_bits,
	output logic [31:0] data_size,
	output logic [31:0] bytes_emitted
);

	logic    accept;
	logic    has_result;
	result_t result;
	result_t out_data;

	assign accept = in_valid & ~in_stall;

	rwpe_parser #(
		.MIN_FILE_BYTES(MIN_FILE_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.file_byte (file_byte),
		.is_final  (is_final),
		.has_result(has_result),
		.result    (result)
	);

	rwpe_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept & has_result),
		.push_data(result),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign pcm_valid     = out_data.pcm_valid;
	assign pcm_out       = out_data.pcm_out;
	assign report_valid  = out_data.report_valid;
	assign status        = out_data.status;
	assign channels      = out_data.channels;
	assign sample_rate   = out_data.sample_rate;
	assign sample_bits   = out_data.sample_bits;
	assign data_size     = out_data.data_size;
	assign bytes_emitted = out_data.bytes_emitted;

endmodule

// ----- design/rwpe_checker.sv -----
module rwpe_checker import rwpe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        pcm_valid,
	input logic [7:0]  pcm_out,
	input logic        report_valid,
	input logic [31:0] data_size,
	input logic [31:0] bytes_emitted
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_some_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pcm_valid || report_valid)
		else $error("result transaction carries neither pcm nor report");

	a_pcm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pcm_valid |-> pcm_out == 8'd0)
		else $error("pcm_out nonzero without pcm_valid");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_valid |-> bytes_emitted <= data_size)
		else $error("bytes_emitted exceeds data_size");

endmodule

bind riff_wave_pcm_extractor rwpe_checker u_rwpe_checker (.*);
